@@ hw/rtl/i2cee_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cee_pkg
// types and fixed codes shared by the serial eeprom device blocks
// ----------------------------------------------------------------------------
package i2cee_pkg;

    // bus event codes
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // bus phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_DEVICE = 3'd1;
    localparam logic [2:0] PH_WORD   = 3'd2;
    localparam logic [2:0] PH_WDATA  = 3'd3;
    localparam logic [2:0] PH_RDATA  = 3'd4;

    localparam logic [6:0] DEV_ADDR_RST = 7'h50;
    localparam logic [7:0] BYTE_ERASED  = 8'hFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_in;
        logic       master_ack;
    } t_in;

    typedef struct packed {
        logic       slave_ack;
        logic [7:0] read_data;
    } t_out;

    // pointer update request from the bus controller
    typedef struct packed {
        logic load;       // load from the word address byte
        logic page_step;  // advance within the page
        logic seq_step;   // advance over the whole array
    } t_ptr_cmd;

endpackage : i2cee_pkg
`default_nettype wire

@@ hw/rtl/i2cee_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cee_ram
// single port synchronous ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module i2cee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule : i2cee_ram
`default_nettype wire

@@ hw/rtl/i2cee_ptr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cee_ptr
// address pointer with page offset tracking, page wrap and array wrap
// ----------------------------------------------------------------------------
module i2cee_ptr #(
    parameter int MEM_BYTES  = 256,
    parameter int PAGE_BYTES = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire i2cee_pkg::t_ptr_cmd   i_cmd,
    input  wire logic [7:0]            i_word,
    output logic [((MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1)-1:0] o_ptr
);
    import i2cee_pkg::*;

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int PW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam logic [PW-1:0] OFF_LAST = PW'(PAGE_BYTES - 1);

    // word address reduced into the array, and its offset in the page
    logic [AW-1:0] w_addr_tbl [256];
    logic [PW-1:0] w_off_tbl  [256];

    for (genvar gi = 0; gi < 256; gi++) begin : g_tbl
        assign w_addr_tbl[gi] = AW'(gi % MEM_BYTES);
        assign w_off_tbl[gi]  = PW'((gi % MEM_BYTES) % PAGE_BYTES);
    end

    logic [AW-1:0] r_ptr, n_ptr;
    logic [PW-1:0] r_off, n_off;
    logic [AW:0]   w_inc;
    logic          w_wrap;
    logic          w_last;

    assign w_inc  = {1'b0, r_ptr} + (AW+1)'(1);
    assign w_wrap = (w_inc == (AW+1)'(MEM_BYTES));
    assign w_last = (r_off == OFF_LAST);

    always_comb begin
        n_ptr = r_ptr;
        n_off = r_off;
        if (i_cmd.load) begin
            n_ptr = w_addr_tbl[i_word];
            n_off = w_off_tbl[i_word];
        end else if (i_cmd.page_step && w_last) begin
            // back to the start of the page
            n_ptr = r_ptr - AW'(r_off);
            n_off = '0;
        end else if (i_cmd.page_step || i_cmd.seq_step) begin
            if (w_wrap) begin
                n_ptr = '0;
                n_off = '0;
            end else begin
                n_ptr = w_inc[AW-1:0];
                n_off = w_last ? '0 : r_off + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_off <= '0;
        end else begin
            r_ptr <= n_ptr;
            r_off <= n_off;
        end
    end

    assign o_ptr = r_ptr;

endmodule : i2cee_ptr
`default_nettype wire

@@ hw/rtl/i2c_serial_eeprom_device_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_serial_eeprom_device_unit
// two-wire serial eeprom device at the level of bus events
// ----------------------------------------------------------------------------
// The device takes one bus event per input transfer (start, stop, byte written
// by the master, byte read with the master's ack) and returns one result
// transfer per event: the device ack and the byte it drives (0xFF when the bus
// is released). The array sits in one single port ram with a registered read.
// Start, stop and write events answer straight into the output register; a read
// in read mode goes through a read state first, as the ram read is registered.
// A new event is taken while the previous result waits, as long as the output
// register is freed in that cycle. After reset a clearing pass writes 0xFF to
// every byte, one byte per cycle, so no event is taken until the pass is over;
// the device address register can be written during that pass. Data bytes take
// effect at once, with no programming delay.
// ----------------------------------------------------------------------------
module i2c_serial_eeprom_device_unit #(
    parameter int MEM_BYTES  = 256,
    parameter int PAGE_BYTES = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // event channel
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire i2cee_pkg::t_in i_in_data,
    // result channel
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output i2cee_pkg::t_out     o_out_data,
    // device address register
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [6:0]     i_cfg_data
);
    import i2cee_pkg::*;

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    // controller states
    localparam logic [1:0] ST_CLEAR = 2'd0;  // erasing the array
    localparam logic [1:0] ST_RUN   = 2'd1;  // taking events
    localparam logic [1:0] ST_READ  = 2'd2;  // waiting on ram read data

    logic [1:0]    r_state, n_state;
    logic [2:0]    r_phase, n_phase;
    logic [6:0]    r_dev_addr;
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic          w_in_fire;
    logic          w_out_free;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_addr;
    logic [7:0]    w_ram_wdata;
    logic [7:0]    w_ram_rdata;
    logic [AW-1:0] w_ptr;
    t_ptr_cmd      w_ptr_cmd;
    logic          w_wr_store;   // data byte goes into the array
    logic          w_rd_issue;   // read in read mode, result comes through the read state
    t_out          w_res;        // result of an event that answers at once

    // output register frees in the cycle its transfer completes
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_RUN) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // device address register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
        end else if (i_cfg_valid) begin
            r_dev_addr <= i_cfg_data;
        end
    end

    // event decode against the bus phase
    always_comb begin
        n_phase    = r_phase;
        w_ptr_cmd  = '0;
        w_wr_store = 1'b0;
        w_rd_issue = 1'b0;
        w_res      = '{slave_ack: 1'b0, read_data: BYTE_ERASED};
        case (i_in_data.kind)
            KIND_START: begin
                n_phase = PH_DEVICE;
            end
            KIND_STOP: begin
                n_phase = PH_IDLE;
            end
            KIND_WRITE: begin
                case (r_phase)
                    PH_DEVICE: begin
                        if (i_in_data.byte_in[7:1] == r_dev_addr) begin
                            w_res.slave_ack = 1'b1;
                            n_phase = i_in_data.byte_in[0] ? PH_RDATA : PH_WORD;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_WORD: begin
                        w_ptr_cmd.load  = 1'b1;
                        w_res.slave_ack = 1'b1;
                        n_phase = PH_WDATA;
                    end
                    PH_WDATA: begin
                        w_wr_store          = 1'b1;
                        w_ptr_cmd.page_step = 1'b1;
                        w_res.slave_ack     = 1'b1;
                    end
                    default: begin
                        // idle or transmitting: byte ignored
                    end
                endcase
            end
            default: begin
                // master read
                if (r_phase == PH_RDATA) begin
                    w_rd_issue         = 1'b1;
                    w_ptr_cmd.seq_step = 1'b1;
                    if (!i_in_data.master_ack) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
        endcase
        // nothing moves without a transfer
        if (!w_in_fire) begin
            n_phase    = r_phase;
            w_ptr_cmd  = '0;
            w_wr_store = 1'b0;
            w_rd_issue = 1'b0;
        end
    end

    // ram port: clearing pass, then data bytes and reads at the pointer
    assign w_ram_we    = (r_state == ST_CLEAR) || w_wr_store;
    assign w_ram_addr  = (r_state == ST_CLEAR) ? r_clr_addr : w_ptr;
    assign w_ram_wdata = (r_state == ST_CLEAR) ? BYTE_ERASED : i_in_data.byte_in;

    i2cee_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    i2cee_ptr #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_ptr_cmd),
        .i_word  (i_in_data.byte_in),
        .o_ptr   (w_ptr)
    );

    // controller state and output register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(MEM_BYTES - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_in_fire) begin
                    if (w_rd_issue) begin
                        n_state = ST_READ;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = w_res;
                    end
                end
            end
            ST_READ: begin
                // the output register was freed when the read was taken
                n_state     = ST_RUN;
                n_out_valid = 1'b1;
                n_out       = '{slave_ack: 1'b0, read_data: w_ram_rdata};
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_phase     <= PH_IDLE;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a pending read always lands in the output register next cycle
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_out_valid && !r_out.slave_ack))
        else $error("read data did not reach the output register");

    // no array write while read data is in flight
    a_no_wr_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !w_ram_we)
        else $error("ram written during a pending read");

    // an acknowledged byte never drives data
    a_ack_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.slave_ack) |-> (r_out.read_data == BYTE_ERASED))
        else $error("ack returned with driven data");

    // events are only taken once the clearing pass is over
    a_no_fire_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !w_in_fire)
        else $error("event taken during clearing pass");

endmodule : i2c_serial_eeprom_device_unit
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// bus event check of the serial eeprom device: directed corner events, then
// random write and read sequences under several device addresses, each result
// compared with a behavioural copy of the array, pointer and bus phase
// ----------------------------------------------------------------------------
module testbench;
    import i2cee_pkg::*;

    localparam int MEM_BYTES   = 256;
    localparam int PAGE_BYTES  = 8;
    localparam int AW          = $clog2(MEM_BYTES);
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int MAX_REPORTS = 10;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 400;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_TOGGLE
    } t_rx_mode;

    // dut ports, all inputs driven to known values from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in        i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out       o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data  = '0;

    // behavioural copy of the device
    logic [7:0]  ee_mem [MEM_BYTES];
    int unsigned ee_ptr;
    logic [2:0]  ee_phase;
    logic [6:0]  ee_dev_addr;

    // bus events waiting to be sent, results waiting to arrive
    t_in  bus_events_q [$];
    t_out expected_resp_q [$];

    // bookkeeping
    int n_queued        = 0;
    int n_checked       = 0;
    int n_errors        = 0;
    int n_acks          = 0;
    int n_rdata         = 0;
    int n_addr_settings = 0;
    int hold_requests   = 0;

    // driver and receiver state
    logic     in_taken   = 1'b0;
    int       gap_left   = 0;
    int       burst_left = 0;
    int       hold_left  = 0;
    int       hold_seen  = 0;
    int       mode_left  = 0;
    t_rx_mode stall_mode = RX_ALWAYS;

    i2c_serial_eeprom_device_unit #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // device behaviour: one bus event in, ack and driven byte out
    // ------------------------------------------------------------------------
    function automatic t_out eeprom_respond(input t_in ev);
        t_out        res;
        int unsigned off;
        res.slave_ack = 1'b0;
        res.read_data = BYTE_ERASED;   // bus released unless a byte is read
        case (ev.kind)
            KIND_START: ee_phase = PH_DEVICE;
            KIND_STOP: ee_phase = PH_IDLE;
            KIND_WRITE: begin
                if (ee_phase == PH_DEVICE) begin
                    // device byte: upper seven bits select, low bit is read/write
                    if (ev.byte_in[7:1] == ee_dev_addr) begin
                        res.slave_ack = 1'b1;
                        ee_phase = ev.byte_in[0] ? PH_RDATA : PH_WORD;
                    end else begin
                        ee_phase = PH_IDLE;
                    end
                end else if (ee_phase == PH_WORD) begin
                    ee_ptr = ev.byte_in % MEM_BYTES;
                    res.slave_ack = 1'b1;
                    ee_phase = PH_WDATA;
                end else if (ee_phase == PH_WDATA) begin
                    // stored at once, pointer wraps inside its page
                    ee_mem[AW'(ee_ptr)] = ev.byte_in;
                    off = ee_ptr % PAGE_BYTES;
                    ee_ptr = (ee_ptr - off + (off + 1) % PAGE_BYTES) % MEM_BYTES;
                    res.slave_ack = 1'b1;
                end
            end
            KIND_READ: begin
                if (ee_phase == PH_RDATA) begin
                    // sequential read wraps over the whole array
                    res.read_data = ee_mem[AW'(ee_ptr)];
                    ee_ptr = (ee_ptr + 1) % MEM_BYTES;
                    if (!ev.master_ack)
                        ee_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic queue_event(input logic [1:0] kind, input logic [7:0] data,
                               input logic mack);
        t_in ev;
        ev.kind       = kind;
        ev.byte_in    = data;
        ev.master_ack = mack;
        bus_events_q.push_back(ev);
        n_queued++;
    endtask

    // start, device byte for write, word address, data bytes, maybe stop
    task automatic queue_page_write(input logic [6:0] dev, input int n_data);
        queue_event(KIND_START, any_byte(), any_bit());
        queue_event(KIND_WRITE, {dev, 1'b0}, any_bit());
        queue_event(KIND_WRITE, any_byte(), any_bit());
        repeat (n_data) queue_event(KIND_WRITE, any_byte(), any_bit());
        if ($urandom_range(0, 99) < 85)
            queue_event(KIND_STOP, any_byte(), any_bit());
    endtask

    // reads with master ack, the last one ended by a nack
    task automatic queue_reads(input int n_reads);
        for (int i = 0; i < n_reads; i++)
            queue_event(KIND_READ, any_byte(), i != n_reads - 1);
        if ($urandom_range(0, 99) < 80)
            queue_event(KIND_STOP, any_byte(), any_bit());
    endtask

    // random read: dummy write of the word address, repeated start, read
    task automatic queue_random_read(input logic [6:0] dev, input int n_reads);
        queue_event(KIND_START, any_byte(), any_bit());
        queue_event(KIND_WRITE, {dev, 1'b0}, any_bit());
        queue_event(KIND_WRITE, any_byte(), any_bit());
        queue_event(KIND_START, any_byte(), any_bit());
        queue_event(KIND_WRITE, {dev, 1'b1}, any_bit());
        queue_reads(n_reads);
    endtask

    // current address read from wherever the pointer stands
    task automatic queue_current_read(input logic [6:0] dev, input int n_reads);
        queue_event(KIND_START, any_byte(), any_bit());
        queue_event(KIND_WRITE, {dev, 1'b1}, any_bit());
        queue_reads(n_reads);
    endtask

    // mostly well-formed sequences, some wrong addresses and loose events
    task automatic queue_random_traffic(input logic [6:0] dev, input int n_items);
        int         target;
        int         pick;
        logic [6:0] other;
        target = n_queued + n_items;
        while (n_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // occasionally long enough to wrap the page more than once
                queue_page_write(dev, ($urandom_range(0, 9) == 0) ?
                                 $urandom_range(9, 20) : $urandom_range(0, 9));
            end else if (pick < 55) begin
                queue_random_read(dev, $urandom_range(1, 12));
            end else if (pick < 72) begin
                queue_current_read(dev, $urandom_range(1, 8));
            end else if (pick < 82) begin
                // address mismatch, followed by events the device must ignore
                other = 7'($urandom_range(0, 127));
                while (other == dev)
                    other = 7'($urandom_range(0, 127));
                queue_event(KIND_START, any_byte(), any_bit());
                queue_event(KIND_WRITE, {other, any_bit()}, any_bit());
                repeat ($urandom_range(1, 3))
                    queue_event(any_bit() ? KIND_READ : KIND_WRITE, any_byte(), any_bit());
            end else begin
                // loose events, breaking up whatever sequence is in progress
                repeat ($urandom_range(1, 4))
                    queue_event(2'($urandom_range(0, 3)), any_byte(), any_bit());
            end
        end
    endtask

    // write the device address register with the block idle
    task automatic write_device_address(input logic [6:0] addr);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        n_addr_settings++;
    endtask

    // sender pause until every queued event has had its result
    task automatic wait_drained();
        while (n_checked != n_queued)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // event driver: bursts of random length with random gaps between them
    // ------------------------------------------------------------------------
    always @(posedge i_clk)
        in_taken <= i_in_valid && o_in_ready;

    always @(negedge i_clk) begin : event_driver
        // a held event stays on the bus until its transfer
        if (!i_in_valid || in_taken) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (bus_events_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= bus_events_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: stall pattern changing at random, plus long hold-offs
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_receiver
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            // block fills up while the sender keeps offering events
            hold_seen   <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_rx_mode'($urandom_range(0, 3));
                mode_left  <= $urandom_range(30, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
                RX_RARELY: i_out_ready <= ($urandom_range(0, 3) == 0);
                RX_TOGGLE: i_out_ready <= ~i_out_ready;
                default:   i_out_ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check results, then predict for newly taken events
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_out want;
        if (o_out_valid && i_out_ready) begin
            if (expected_resp_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected result: ack %0b data %02h",
                             o_out_data.slave_ack, o_out_data.read_data);
            end else begin
                want = expected_resp_q.pop_front();
                n_checked++;
                if (o_out_data.slave_ack !== want.slave_ack ||
                    o_out_data.read_data !== want.read_data) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("result %0d: expected ack %0b data %02h, got ack %0b data %02h",
                                 n_checked, want.slave_ack, want.read_data,
                                 o_out_data.slave_ack, o_out_data.read_data);
                end
            end
        end
        // a result never leaves in the cycle its event is taken
        if (i_in_valid && o_in_ready) begin
            if (i_in_data.kind == KIND_READ && ee_phase == PH_RDATA)
                n_rdata++;
            want = eeprom_respond(i_in_data);
            n_acks += want.slave_ack;
            expected_resp_q.push_back(want);
        end
        if (i_cfg_valid && o_cfg_ready)
            ee_dev_addr = i_cfg_data;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [6:0] dev_plan [PHASES];
        logic [6:0] rst_dev;
        for (int i = 0; i < MEM_BYTES; i++)
            ee_mem[AW'(i)] = BYTE_ERASED;
        ee_ptr      = 0;
        ee_phase    = PH_IDLE;
        ee_dev_addr = DEV_ADDR_RST;
        rst_dev     = DEV_ADDR_RST;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part with the address left at its reset value;
        // events sit in the driver until the clearing pass has finished
        queue_event(KIND_READ, 8'hFF, 1'b1);              // read while idle
        queue_event(KIND_WRITE, 8'h00, 1'b0);             // write while idle
        queue_event(KIND_STOP, 8'h00, 1'b0);
        queue_event(KIND_START, 8'hFF, 1'b1);
        queue_event(KIND_WRITE, {rst_dev, 1'b0}, 1'b0);
        queue_event(KIND_WRITE, 8'hFF, 1'b1);             // word address at the top
        queue_event(KIND_WRITE, 8'h00, 1'b0);             // last byte, wraps to page start
        queue_event(KIND_WRITE, 8'h5A, 1'b1);
        queue_event(KIND_READ, 8'h00, 1'b1);              // read outside read mode
        queue_event(KIND_START, 8'h00, 1'b0);             // repeated start
        queue_event(KIND_WRITE, {rst_dev ^ 7'h01, 1'b0}, 1'b1); // address mismatch
        queue_event(KIND_WRITE, 8'h12, 1'b0);             // ignored after mismatch
        queue_event(KIND_START, 8'h00, 1'b0);
        queue_event(KIND_WRITE, {rst_dev, 1'b0}, 1'b1);
        queue_event(KIND_READ, 8'h00, 1'b1);              // read while expecting address
        queue_event(KIND_WRITE, 8'hFE, 1'b0);
        queue_event(KIND_START, 8'h00, 1'b1);
        queue_event(KIND_WRITE, {rst_dev, 1'b1}, 1'b0);
        queue_event(KIND_WRITE, 8'h33, 1'b1);             // write while transmitting
        queue_event(KIND_READ, 8'h00, 1'b1);
        queue_event(KIND_READ, 8'h00, 1'b1);              // top byte, pointer wraps to zero
        queue_event(KIND_READ, 8'h00, 1'b0);              // master nack ends the read
        queue_event(KIND_READ, 8'h00, 1'b1);              // read after nack, bus released
        queue_event(KIND_START, 8'h00, 1'b0);
        queue_event(KIND_WRITE, {rst_dev, 1'b1}, 1'b1);   // current address read
        queue_event(KIND_READ, 8'hFF, 1'b0);
        queue_event(KIND_STOP, 8'hFF, 1'b1);

        // random part, one device address per phase, extremes first
        dev_plan[0] = 7'h00;
        dev_plan[1] = 7'h7F;
        dev_plan[2] = 7'($urandom_range(1, 126));
        dev_plan[3] = DEV_ADDR_RST;
        dev_plan[4] = 7'($urandom_range(1, 126));
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_device_address(dev_plan[p]);
            queue_random_traffic(dev_plan[p], PHASE_ITEMS);
            if (p == 1 || p == 3)
                hold_requests++;
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (expected_resp_q.size() != 0) begin
            n_errors++;
            $display("%0d results never arrived", expected_resp_q.size());
        end

        $display("checked %0d bus events under %0d written device addresses",
                 n_checked, n_addr_settings);
        $display("%0d bytes acknowledged, %0d bytes read back, %0d mismatches",
                 n_acks, n_rdata, n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("timeout with %0d of %0d results checked", n_checked, n_queued);
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_ram.sv
hw/rtl/i2cee_ptr.sv
hw/rtl/i2c_serial_eeprom_device_unit.sv
dv/testbench.sv
